### rtl/sha1md_pkg.sv
// SHA-1 message digest: shared types and constants.
// Used by every module of the core; no dependencies.
`default_nettype none

package sha1md_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_item_t;

    // One 32-bit message schedule word on its way to the compression engine.
    typedef struct packed {
        logic [31:0] word;
        logic        last;   // word 15 of the closing block of a message
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [2:0] LAST_INDEX = 3'd4;

endpackage

`default_nettype wire

### rtl/sha1md_front.sv
// SHA-1 front end: packs message bytes into big-endian words, adds padding
// and the bit length. Depends on sha1md_pkg.
`default_nettype none

module sha1md_front
    import sha1md_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      msg_valid,
    output logic           msg_stall,
    input  wire msg_item_t msg,
    output logic           q_push,
    output q_entry_t       q_wr,
    input  wire q_stat_t   q_stat
);

    localparam logic [1:0] F_TAKE = 2'd0;
    localparam logic [1:0] F_PAD1 = 2'd1;
    localparam logic [1:0] F_PAD  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [23:0] acc_reg, acc_next;
    logic [1:0]  bpos_reg, bpos_next;
    logic [3:0]  wpos_reg, wpos_next;
    logic [60:0] len_reg, len_next;
    logic        len_ok_reg, len_ok_next;
    logic        take;
    logic [63:0] len_bits;

    assign len_bits  = {len_reg, 3'b000};
    assign msg_stall = (state_reg != F_TAKE) || q_stat.full;
    assign take      = msg_valid && !msg_stall;

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        bpos_next   = bpos_reg;
        wpos_next   = wpos_reg;
        len_next    = len_reg;
        len_ok_next = len_ok_reg;
        q_push      = 1'b0;
        q_wr.word   = {acc_reg, msg.data_byte};
        q_wr.last   = 1'b0;
        case (state_reg)
            F_TAKE:
            begin
                if (take)
                begin
                    if (msg.has_byte)
                    begin
                        acc_next  = {acc_reg[15:0], msg.data_byte};
                        bpos_next = bpos_reg + 2'd1;
                        len_next  = len_reg + 61'd1;
                        if (bpos_reg == 2'd3)
                        begin
                            q_push    = 1'b1;
                            wpos_next = wpos_reg + 4'd1;
                        end
                    end
                    if (msg.end_of_message)
                    begin
                        state_next = F_PAD1;
                    end
                end
            end
            F_PAD1:
            begin
                case (bpos_reg)
                    2'd0:    q_wr.word = {PAD_BYTE, 24'h0};
                    2'd1:    q_wr.word = {acc_reg[7:0], PAD_BYTE, 16'h0};
                    2'd2:    q_wr.word = {acc_reg[15:0], PAD_BYTE, 8'h0};
                    default: q_wr.word = {acc_reg, PAD_BYTE};
                endcase
                q_push = !q_stat.full;
                if (!q_stat.full)
                begin
                    wpos_next   = wpos_reg + 4'd1;
                    bpos_next   = 2'd0;
                    // pad in word 15 opens a fresh block, so the length fits there too
                    len_ok_next = (wpos_reg != 4'd14);
                    state_next  = F_PAD;
                end
            end
            F_PAD:
            begin
                if (len_ok_reg && wpos_reg == 4'd14)
                begin
                    q_wr.word = len_bits[63:32];
                end
                else if (len_ok_reg && wpos_reg == 4'd15)
                begin
                    q_wr.word = len_bits[31:0];
                end
                else
                begin
                    q_wr.word = 32'h0;
                end
                q_wr.last = len_ok_reg && (wpos_reg == 4'd15);
                q_push    = !q_stat.full;
                if (!q_stat.full)
                begin
                    wpos_next = wpos_reg + 4'd1;
                    if (wpos_reg == 4'd15)
                    begin
                        len_ok_next = 1'b1;
                    end
                    if (q_wr.last)
                    begin
                        len_next    = '0;
                        len_ok_next = 1'b0;
                        state_next  = F_TAKE;
                    end
                end
            end
            default:
            begin
                state_next = F_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_TAKE;
            bpos_reg   <= '0;
            wpos_reg   <= '0;
            len_reg    <= '0;
            len_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bpos_reg   <= bpos_next;
            wpos_reg   <= wpos_next;
            len_reg    <= len_next;
            len_ok_reg <= len_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

### rtl/sha1md_fifo.sv
// SHA-1 word queue between the front end and the compression engine.
// Register-based FIFO; depends on sha1md_pkg.
`default_nettype none

module sha1md_fifo
    import sha1md_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t wr,
    input  wire logic     pop,
    output q_entry_t      rd,
    output q_stat_t       stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    q_entry_t        mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd         = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr;
        end
    end

endmodule

`default_nettype wire

### rtl/sha1md_core.sv
// SHA-1 compression engine: one round per cycle if fed, over a 16-word
// schedule window, chaining update, digest out. Depends on sha1md_pkg.
`default_nettype none

module sha1md_core
    import sha1md_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire q_entry_t q_rd,
    input  wire q_stat_t  q_stat,
    output logic          q_pop,
    output logic          dig_valid,
    input  wire logic     dig_stall,
    output dig_item_t     dig
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_ROUND = 2'd1;
    localparam logic [1:0] B_ADD   = 2'd2;
    localparam logic [1:0] B_OUT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [4:0][31:0]  h_reg, h_next;
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]       a_next, b_next, c_next, d_next, e_next;
    logic [15:0][31:0] w_reg, w_next;
    logic [6:0]        t_reg, t_next;
    logic              fin_reg, fin_next;
    logic [2:0]        idx_reg, idx_next;
    logic              need_q, step;
    logic [31:0]       wx, wt, f, k, sum;

    assign need_q = (t_reg < 7'd16);
    assign step   = (state_reg == B_ROUND) && (!need_q || !q_stat.empty);
    assign q_pop  = (state_reg == B_ROUND) && need_q && !q_stat.empty;
    assign wx     = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign wt     = need_q ? q_rd.word : {wx[30:0], wx[31]};

    always_comb
    begin
        if (t_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = K_0;
        end
        else if (t_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K_1;
        end
        else if (t_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K_2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K_3;
        end
    end

    assign sum = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wt;

    assign dig_valid       = (state_reg == B_OUT);
    assign dig.digest_word = h_reg[idx_reg];
    assign dig.word_index  = idx_reg;
    assign dig.last_word   = (idx_reg == LAST_INDEX);

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        w_next     = w_reg;
        t_next     = t_reg;
        fin_next   = fin_reg;
        idx_next   = idx_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    a_next     = h_reg[0];
                    b_next     = h_reg[1];
                    c_next     = h_reg[2];
                    d_next     = h_reg[3];
                    e_next     = h_reg[4];
                    t_next     = '0;
                    state_next = B_ROUND;
                end
            end
            B_ROUND:
            begin
                if (step)
                begin
                    a_next = sum;
                    b_next = a_reg;
                    c_next = {b_reg[1:0], b_reg[31:2]};
                    d_next = c_reg;
                    e_next = d_reg;
                    w_next = {wt, w_reg[15:1]};
                    t_next = t_reg + 7'd1;
                    if (t_reg == 7'd15)
                    begin
                        fin_next = q_rd.last;
                    end
                    if (t_reg == 7'd79)
                    begin
                        state_next = B_ADD;
                    end
                end
            end
            B_ADD:
            begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                h_next[4]  = h_reg[4] + e_reg;
                idx_next   = '0;
                state_next = fin_reg ? B_OUT : B_IDLE;
            end
            B_OUT:
            begin
                if (!dig_stall)
                begin
                    if (idx_reg == LAST_INDEX)
                    begin
                        h_next     = H_INIT;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            h_reg     <= H_INIT;
            t_reg     <= '0;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            t_reg     <= t_next;
            fin_reg   <= fin_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        w_reg <= w_next;
    end

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_ROUND |-> t_reg <= 7'd79)
        else $error("round counter past 79");

    a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_ADD |-> $past(state_reg) == B_ROUND && $past(t_reg) == 7'd79)
        else $error("chaining update without a full set of rounds");

    a_chain_restart: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_stall && dig.last_word |=> h_reg == H_INIT)
        else $error("chaining words not restored after digest");

endmodule

`default_nettype wire

### rtl/sha1_message_digest_core.sv
// Streaming SHA-1: one byte per transaction in, five digest words out per message.
// A block's chaining update is registered in the add state after its last round;
// after the closing block's update, the output state presents the digest words.
// Throughput: one byte per cycle while the word queue has room and no padding is
// pending; only QUEUE_DEPTH words queue up during the 64 rounds that take none.
// Reset: chaining words to SHA-1 initial values, counts and queue cleared at once.
`default_nettype none

module sha1_message_digest_core
    import sha1md_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      msg_valid,
    output logic           msg_stall,
    input  wire msg_item_t msg,
    output logic           dig_valid,
    input  wire logic      dig_stall,
    output dig_item_t      dig
);

    logic     q_push, q_pop;
    q_entry_t q_wr, q_rd;
    q_stat_t  q_stat;

    sha1md_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .q_push    (q_push),
        .q_wr      (q_wr),
        .q_stat    (q_stat)
    );

    sha1md_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wr    (q_wr),
        .pop   (q_pop),
        .rd    (q_rd),
        .stat  (q_stat)
    );

    sha1md_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

endmodule

`default_nettype wire
